>>> rtl/jec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jec_pkg
// Shared constants, codes and types of the joystick event conditioner.
// ----------------------------------------------------------------------------
package jec_pkg;

	localparam int NUM_AXES    = 8;
	localparam int NUM_BUTTONS = 16;
	localparam int TIME_W      = 32;

	localparam int OP_W       = 2;
	localparam int AX_IDX_W   = 3;
	localparam int BT_IDX_W   = 4;
	localparam int RAW_W      = 16;
	localparam int POS_W      = 16;
	localparam int LIM_W      = 15;
	localparam int TICKS_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int ONE_Q14   = 16384;
	localparam int QUO_W     = 14;
	localparam int DIV_W     = 17;
	localparam int WIDE_W    = 18;
	localparam int DIV_CNT_W = 4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [OP_W-1:0] {
		OP_TICK,
		OP_AXIS,
		OP_BTN_DOWN,
		OP_BTN_UP
	} op_t;

	typedef enum logic [1:0] {
		HS_IDLE,
		HS_PRESSED,
		HS_SHORT,
		HS_HELD
	} hold_t;

	typedef enum logic [1:0] {
		PC_NONE,
		PC_SHORT,
		PC_LONG
	} press_t;

	typedef enum logic [1:0] {
		AX_ZERO,
		AX_SAT,
		AX_DIV
	} ax_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AXIS_LOW,
		CFG_AXIS_HIGH,
		CFG_DEAD_ZONE,
		CFG_INVERT,
		CFG_LONG_PRESS,
		CFG_HOLD,
		CFG_SL_MASK,
		CFG_SH_MASK
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_BTN,
		BK_DIV,
		BK_EMIT
	} bk_state_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] axis_low;
		logic [LIM_W-1:0]        axis_high;
		logic [LIM_W-1:0]        dead_zone;
		logic [NUM_AXES-1:0]     invert;
		logic [TICKS_W-1:0]      long_press;
		logic [TICKS_W-1:0]      hold;
		logic [NUM_BUTTONS-1:0]  sl_mask;
		logic [NUM_BUTTONS-1:0]  sh_mask;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [AX_IDX_W-1:0] ax;
		logic [BT_IDX_W-1:0] bt;
		ax_mode_t            mode;
		logic                neg;
		logic [DIV_W-1:0]    num;
		logic [DIV_W-1:0]    den;
	} cmd_t;

endpackage

>>> rtl/joystick_event_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_event_conditioner
// The back end handles a button event in its button state, emits an axis
// motion in the dead zone or at a limit directly, runs a divided axis position
// through the 14-step divider and a tick through the one-button-per-cycle tick
// scan; it takes no new command until the last is in the output register. A
// two-entry queue lets the input side run ahead by two beats. Reset clears the
// time counter, press times and hold states and loads the register defaults.
// ----------------------------------------------------------------------------
module joystick_event_conditioner (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [jec_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [jec_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [jec_pkg::OP_W-1:0]             op,
	input  logic [jec_pkg::AX_IDX_W-1:0]         axis_index,
	input  logic signed [jec_pkg::RAW_W-1:0]     axis_raw,
	input  logic [jec_pkg::BT_IDX_W-1:0]         button_index,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [jec_pkg::OP_W-1:0]             event_kind,
	output logic [jec_pkg::AX_IDX_W-1:0]         axis_slot,
	output logic signed [jec_pkg::POS_W-1:0]     axis_position,
	output logic [jec_pkg::BT_IDX_W-1:0]         button_slot,
	output logic [1:0]                           press_class,
	output logic [1:0]                           hold_status,
	output logic [jec_pkg::NUM_BUTTONS-1:0]      newly_held_mask
);

	jec_pkg::cfg_t cfg_q;
	jec_pkg::cmd_t push_cmd, pop_cmd;
	logic          q_full, q_empty, q_push, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_low   <= 16'sh8000;
			cfg_q.axis_high  <= 15'h7fff;
			cfg_q.dead_zone  <= '0;
			cfg_q.invert     <= '0;
			cfg_q.long_press <= 24'd1000;
			cfg_q.hold       <= 24'd1000;
			cfg_q.sl_mask    <= '0;
			cfg_q.sh_mask    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (jec_pkg::cfg_reg_t'(cfg_index))
				jec_pkg::CFG_AXIS_LOW:   cfg_q.axis_low   <= cfg_data[jec_pkg::RAW_W-1:0];
				jec_pkg::CFG_AXIS_HIGH:  cfg_q.axis_high  <= cfg_data[jec_pkg::LIM_W-1:0];
				jec_pkg::CFG_DEAD_ZONE:  cfg_q.dead_zone  <= cfg_data[jec_pkg::LIM_W-1:0];
				jec_pkg::CFG_INVERT:     cfg_q.invert     <= cfg_data[jec_pkg::NUM_AXES-1:0];
				jec_pkg::CFG_LONG_PRESS: cfg_q.long_press <= cfg_data[jec_pkg::TICKS_W-1:0];
				jec_pkg::CFG_HOLD:       cfg_q.hold       <= cfg_data[jec_pkg::TICKS_W-1:0];
				jec_pkg::CFG_SL_MASK:    cfg_q.sl_mask    <= cfg_data[jec_pkg::NUM_BUTTONS-1:0];
				jec_pkg::CFG_SH_MASK:    cfg_q.sh_mask    <= cfg_data[jec_pkg::NUM_BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	jec_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.axis_index   (axis_index),
		.axis_raw     (axis_raw),
		.button_index (button_index),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (push_cmd)
	);

	jec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	jec_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_cmd           (pop_cmd),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_kind      (event_kind),
		.axis_slot       (axis_slot),
		.axis_position   (axis_position),
		.button_slot     (button_slot),
		.press_class     (press_class),
		.hold_status     (hold_status),
		.newly_held_mask (newly_held_mask)
	);

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (axis_position <= 16'sd16384 && axis_position >= -16'sd16384))
		else $error("axis position out of Q1.14 range");

	a_axis_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != jec_pkg::OP_AXIS |-> axis_position == '0 && axis_slot == '0)
		else $error("axis fields set on a non-axis beat");

	a_newly_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != jec_pkg::OP_TICK |-> newly_held_mask == '0)
		else $error("newly held mask set outside a tick");

	a_press_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> press_class != 2'd3 &&
			(event_kind == jec_pkg::OP_BTN_UP || press_class == jec_pkg::PC_NONE))
		else $error("press class outside a button release");

endmodule

>>> rtl/jec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jec_front
// Accepts event beats and classifies axis motion into zero, saturate or divide.
// ----------------------------------------------------------------------------
module jec_front (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [jec_pkg::OP_W-1:0]      op,
	input  logic [jec_pkg::AX_IDX_W-1:0]  axis_index,
	input  logic signed [jec_pkg::RAW_W-1:0] axis_raw,
	input  logic [jec_pkg::BT_IDX_W-1:0]  button_index,
	input  jec_pkg::cfg_t                 cfg,
	input  logic                          q_full,
	output logic                          q_push,
	output jec_pkg::cmd_t                 q_cmd
);

	logic signed [jec_pkg::WIDE_W-1:0] x, dz, hi, lo;
	logic signed [jec_pkg::WIDE_W-1:0] num_pos, den_pos, num_neg, den_neg;
	logic                              ax_ok;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		x  = {{(jec_pkg::WIDE_W - jec_pkg::RAW_W){axis_raw[jec_pkg::RAW_W-1]}}, axis_raw};
		dz = {{(jec_pkg::WIDE_W - jec_pkg::LIM_W){1'b0}}, cfg.dead_zone};
		hi = {{(jec_pkg::WIDE_W - jec_pkg::LIM_W){1'b0}}, cfg.axis_high};
		lo = {{(jec_pkg::WIDE_W - jec_pkg::RAW_W){cfg.axis_low[jec_pkg::RAW_W-1]}},
			cfg.axis_low};
		num_pos = x - dz;
		den_pos = hi - dz;
		num_neg = -(x + dz);
		den_neg = -(lo + dz);
		ax_ok   = {1'b0, axis_index} < (jec_pkg::AX_IDX_W + 1)'(jec_pkg::NUM_AXES);

		q_cmd.op   = jec_pkg::op_t'(op);
		q_cmd.ax   = axis_index;
		q_cmd.bt   = button_index;
		q_cmd.mode = jec_pkg::AX_ZERO;
		q_cmd.neg  = 1'b0;
		q_cmd.num  = num_pos[jec_pkg::DIV_W-1:0];
		q_cmd.den  = den_pos[jec_pkg::DIV_W-1:0];

		if (!ax_ok || (x <= dz && x >= -dz)) begin
			q_cmd.mode = jec_pkg::AX_ZERO;
		end else if (x > dz) begin
			q_cmd.mode = (x >= hi) ? jec_pkg::AX_SAT : jec_pkg::AX_DIV;
		end else begin
			q_cmd.mode = (x <= lo) ? jec_pkg::AX_SAT : jec_pkg::AX_DIV;
			q_cmd.neg  = 1'b1;
			q_cmd.num  = num_neg[jec_pkg::DIV_W-1:0];
			q_cmd.den  = den_neg[jec_pkg::DIV_W-1:0];
		end

		if (ax_ok && cfg.invert[axis_index]) begin
			q_cmd.neg = !q_cmd.neg;
		end
	end

endmodule

>>> rtl/jec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jec_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module jec_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jec_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output jec_pkg::cmd_t pop_cmd,
	output logic          empty
);

	jec_pkg::cmd_t                  mem_q [jec_pkg::QUEUE_DEPTH];
	logic [jec_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [jec_pkg::QCNT_W-1:0]     count_q;

	assign full    = count_q == jec_pkg::QCNT_W'(jec_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == jec_pkg::QPTR_W'(jec_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == jec_pkg::QPTR_W'(jec_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/jec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jec_back
// Executes queued commands: tick scan, button tracking, iterative axis divide.
// ----------------------------------------------------------------------------
module jec_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  jec_pkg::cfg_t                     cfg,
	input  logic                              q_empty,
	input  jec_pkg::cmd_t                     q_cmd,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [jec_pkg::OP_W-1:0]          event_kind,
	output logic [jec_pkg::AX_IDX_W-1:0]      axis_slot,
	output logic signed [jec_pkg::POS_W-1:0]  axis_position,
	output logic [jec_pkg::BT_IDX_W-1:0]      button_slot,
	output logic [1:0]                        press_class,
	output logic [1:0]                        hold_status,
	output logic [jec_pkg::NUM_BUTTONS-1:0]   newly_held_mask
);

	jec_pkg::bk_state_t state_q, state_d;
	jec_pkg::cmd_t      cur_q;

	logic [jec_pkg::TIME_W-1:0]   tick_q;
	logic [jec_pkg::TIME_W-1:0]   sl_time_q [jec_pkg::NUM_BUTTONS];
	logic [jec_pkg::TIME_W-1:0]   sh_time_q [jec_pkg::NUM_BUTTONS];
	jec_pkg::hold_t               hold_q [jec_pkg::NUM_BUTTONS];

	logic [jec_pkg::BT_IDX_W-1:0]    scan_idx_q;
	logic [jec_pkg::NUM_BUTTONS-1:0] newly_q;
	logic [jec_pkg::DIV_W-1:0]       rem_q;
	logic [jec_pkg::QUO_W-1:0]       quo_q;
	logic [jec_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic signed [jec_pkg::POS_W-1:0] res_pos_q;
	jec_pkg::press_t                 res_pc_q;
	jec_pkg::hold_t                  res_hs_q;

	logic                              out_valid_q;
	logic [jec_pkg::OP_W-1:0]          kind_q;
	logic [jec_pkg::AX_IDX_W-1:0]      ax_slot_q;
	logic signed [jec_pkg::POS_W-1:0]  pos_q;
	logic [jec_pkg::BT_IDX_W-1:0]      bt_slot_q;
	logic [1:0]                        pc_q, hs_q;
	logic [jec_pkg::NUM_BUTTONS-1:0]   newly_out_q;

	logic out_free, load_out, scan_last, div_last;
	logic scan_hit;
	logic [jec_pkg::TIME_W-1:0] scan_elapsed, sl_elapsed;
	logic bt_ok, bt_sl, bt_sh;
	jec_pkg::hold_t  hs_cur, hs_new;
	jec_pkg::press_t pc_new;
	logic [jec_pkg::DIV_W-1:0] rem_dbl, rem_next;
	logic                      div_ge;
	logic signed [jec_pkg::POS_W-1:0] sat_mag, div_mag, pos_fin;

	assign out_free  = !out_valid_q || out_ready;
	assign scan_last = scan_idx_q == jec_pkg::BT_IDX_W'(jec_pkg::NUM_BUTTONS - 1);
	assign div_last  = div_cnt_q == jec_pkg::DIV_CNT_W'(jec_pkg::QUO_W - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			jec_pkg::BK_IDLE: begin
				if (!q_empty) begin
					case (q_cmd.op)
						jec_pkg::OP_TICK: state_d = jec_pkg::BK_SCAN;
						jec_pkg::OP_AXIS: state_d = (q_cmd.mode == jec_pkg::AX_DIV) ?
							jec_pkg::BK_DIV : jec_pkg::BK_EMIT;
						default:          state_d = jec_pkg::BK_BTN;
					endcase
				end
			end
			jec_pkg::BK_SCAN: if (scan_last) state_d = jec_pkg::BK_EMIT;
			jec_pkg::BK_BTN:  state_d = jec_pkg::BK_EMIT;
			jec_pkg::BK_DIV:  if (div_last) state_d = jec_pkg::BK_EMIT;
			jec_pkg::BK_EMIT: if (out_free) state_d = jec_pkg::BK_IDLE;
			default:          state_d = jec_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			jec_pkg::BK_IDLE: q_pop    = !q_empty;
			jec_pkg::BK_EMIT: load_out = out_free;
			default: begin
				q_pop    = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_comb begin
		scan_elapsed = tick_q - sh_time_q[scan_idx_q];
		scan_hit = cfg.sh_mask[scan_idx_q] && (hold_q[scan_idx_q] == jec_pkg::HS_PRESSED) &&
			(scan_elapsed >= {{(jec_pkg::TIME_W - jec_pkg::TICKS_W){1'b0}}, cfg.hold});

		bt_ok  = {1'b0, cur_q.bt} < (jec_pkg::BT_IDX_W + 1)'(jec_pkg::NUM_BUTTONS);
		bt_sl  = cfg.sl_mask[cur_q.bt];
		bt_sh  = cfg.sh_mask[cur_q.bt];
		hs_cur = hold_q[cur_q.bt];
		sl_elapsed = tick_q - sl_time_q[cur_q.bt];
		hs_new = hs_cur;
		pc_new = jec_pkg::PC_NONE;
		if (cur_q.op == jec_pkg::OP_BTN_DOWN) begin
			if (bt_sh) hs_new = jec_pkg::HS_PRESSED;
		end else begin
			if (bt_sl) begin
				pc_new = (sl_elapsed >= {{(jec_pkg::TIME_W - jec_pkg::TICKS_W){1'b0}},
					cfg.long_press}) ? jec_pkg::PC_LONG : jec_pkg::PC_SHORT;
			end
			if (bt_sh && hs_cur == jec_pkg::HS_PRESSED) hs_new = jec_pkg::HS_SHORT;
			else if (bt_sh && hs_cur == jec_pkg::HS_HELD) hs_new = jec_pkg::HS_IDLE;
		end

		rem_dbl  = {rem_q[jec_pkg::DIV_W-2:0], 1'b0};
		div_ge   = rem_dbl >= cur_q.den;
		rem_next = div_ge ? rem_dbl - cur_q.den : rem_dbl;

		sat_mag = (q_cmd.mode == jec_pkg::AX_SAT) ? jec_pkg::POS_W'(jec_pkg::ONE_Q14) : '0;
		div_mag = {{(jec_pkg::POS_W - jec_pkg::QUO_W){1'b0}}, quo_q};
		if (cur_q.mode == jec_pkg::AX_DIV) begin
			pos_fin = cur_q.neg ? -div_mag : div_mag;
		end else begin
			pos_fin = res_pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jec_pkg::BK_IDLE;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < jec_pkg::NUM_BUTTONS; i++) begin
				sl_time_q[i] <= '0;
				sh_time_q[i] <= '0;
				hold_q[i]    <= jec_pkg::HS_IDLE;
			end
		end else begin
			state_q <= state_d;
			if (q_pop && q_cmd.op == jec_pkg::OP_TICK) begin
				tick_q <= tick_q + 1'b1;
			end
			if (state_q == jec_pkg::BK_SCAN && scan_hit) begin
				hold_q[scan_idx_q] <= jec_pkg::HS_HELD;
			end
			if (state_q == jec_pkg::BK_BTN && bt_ok) begin
				hold_q[cur_q.bt] <= hs_new;
				if (cur_q.op == jec_pkg::OP_BTN_DOWN && bt_sl) sl_time_q[cur_q.bt] <= tick_q;
				if (cur_q.op == jec_pkg::OP_BTN_DOWN && bt_sh) sh_time_q[cur_q.bt] <= tick_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q      <= q_cmd;
			scan_idx_q <= '0;
			newly_q    <= '0;
			rem_q      <= q_cmd.num;
			quo_q      <= '0;
			div_cnt_q  <= '0;
			res_pos_q  <= q_cmd.neg ? -sat_mag : sat_mag;
		end
		if (state_q == jec_pkg::BK_SCAN) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (scan_hit) newly_q[scan_idx_q] <= 1'b1;
		end
		if (state_q == jec_pkg::BK_BTN) begin
			res_pc_q <= bt_ok ? pc_new : jec_pkg::PC_NONE;
			res_hs_q <= bt_ok ? hs_new : jec_pkg::HS_IDLE;
		end
		if (state_q == jec_pkg::BK_DIV) begin
			rem_q     <= rem_next;
			quo_q     <= {quo_q[jec_pkg::QUO_W-2:0], div_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (load_out) begin
			kind_q <= cur_q.op;
			case (cur_q.op)
				jec_pkg::OP_TICK: begin
					ax_slot_q   <= '0;
					pos_q       <= '0;
					bt_slot_q   <= '0;
					pc_q        <= jec_pkg::PC_NONE;
					hs_q        <= jec_pkg::HS_IDLE;
					newly_out_q <= newly_q;
				end
				jec_pkg::OP_AXIS: begin
					ax_slot_q   <= cur_q.ax;
					pos_q       <= pos_fin;
					bt_slot_q   <= '0;
					pc_q        <= jec_pkg::PC_NONE;
					hs_q        <= jec_pkg::HS_IDLE;
					newly_out_q <= '0;
				end
				default: begin
					ax_slot_q   <= '0;
					pos_q       <= '0;
					bt_slot_q   <= cur_q.bt;
					pc_q        <= res_pc_q;
					hs_q        <= res_hs_q;
					newly_out_q <= '0;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign event_kind      = kind_q;
	assign axis_slot       = ax_slot_q;
	assign axis_position   = pos_q;
	assign button_slot     = bt_slot_q;
	assign press_class     = pc_q;
	assign hold_status     = hs_q;
	assign newly_held_mask = newly_out_q;

endmodule
